// ===== hw/rtl/crcsc_pkg.sv =====
// crcsc_pkg: shared types and constants for the crc codeword stream checker
// no dependencies; used by the top level and the remainder unit

package crcsc_pkg;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_GEN_BITS      = 2'd0,
    CFG_GEN_LENGTH    = 2'd1,
    CFG_WIDE_DATAWORD = 2'd2
  } cfg_reg_e;

  // header parsing phase
  typedef enum logic [1:0] {
    PH_PAD_COUNT  = 2'd0,
    PH_FIRST_BYTE = 2'd1,
    PH_STREAM     = 2'd2
  } phase_e;

  // register reset values
  localparam logic [15:0] GEN_BITS_RESET   = 16'd11;
  localparam logic [4:0]  GEN_LENGTH_RESET = 5'd4;

  // codeword fill counter saturates here
  localparam logic [4:0] FILL_MAX = 5'd31;

  // padding counts at or above this drop the whole first stream byte
  localparam logic [3:0] PAD_MAX = 4'd8;

  // dataword sizes
  localparam logic [3:0] NARROW_DATA_BITS = 4'd4;
  localparam logic [3:0] WIDE_DATA_BITS   = 4'd8;

  // one result as held in the output buffer
  typedef struct packed {
    logic [7:0]  out_byte;
    logic        out_valid;
    logic [31:0] total_codewords;
    logic [31:0] error_codewords;
  } result_t;

  // dataword bits and check outcome of one codeword
  typedef struct packed {
    logic [7:0] data;
    logic       error;
  } check_t;

endpackage

// ===== hw/rtl/crcsc_divider.sv =====
// crcsc_divider: modulo-2 remainder check of one left-aligned codeword
// depends on crcsc_pkg for the check result type

module crcsc_divider #(
  parameter int unsigned SHIFT_WIDTH = 23
) (
  input  logic [SHIFT_WIDTH-1:0] codeword_i,   // first codeword bit at msb
  input  logic [SHIFT_WIDTH-1:0] generator_i,  // leading term at msb
  input  logic                   wide_i,
  output crcsc_pkg::check_t      check_o
);

  logic [SHIFT_WIDTH-1:0] rem;

  // one long-division step per dataword bit, four or eight of them
  always_comb begin
    rem = codeword_i;
    for (int i = 0; i < 8; i++) begin
      if ((i < 4 || wide_i) && rem[SHIFT_WIDTH-1-i]) begin
        rem = rem ^ (generator_i >> i);
      end
    end
  end

  // data bits lead the codeword; the check bits sit right below them
  always_comb begin
    if (wide_i) begin
      check_o.data  = codeword_i[SHIFT_WIDTH-1 -: 8];
      check_o.error = |rem[SHIFT_WIDTH-9:0];
    end else begin
      check_o.data  = {4'd0, codeword_i[SHIFT_WIDTH-1 -: 4]};
      check_o.error = |rem[SHIFT_WIDTH-5:0];
    end
  end

endmodule

// ===== hw/rtl/crc_codeword_stream_checker.sv =====
// crc_codeword_stream_checker: top level, header parsing, codeword framing,
// data byte packing, saturating counters and output buffer
// depends on crcsc_pkg and crcsc_divider
//
//  channel   handshake                      payload
//  --------  -----------------------------  -------------------------------------------
//  cfg       cfg_valid_i / cfg_ready_o      cfg_index_i, cfg_data_i
//  request   req_valid_i / req_stall_o      in_byte_i
//  result    rsp_valid_o / rsp_stall_i      out_byte_o, out_valid_o, total_codewords_o,
//                                           error_codewords_o
//
// one request per clock while req_stall_o is low; each accepted byte gives exactly
// one result, written to the output buffer at the edge of acceptance.
// the rate rests on the codeword register absorbing a whole byte per update, with
// two remainder units side by side for the up to two codewords one byte closes.
// reset is asynchronous and clears all control state; no clearing pass.
// a two-entry output buffer decouples the sides: req_stall_o rises only when
// both entries hold results that the result side has not taken.

module crc_codeword_stream_checker #(
  parameter int unsigned GEN_MAX_LENGTH = 16,
  parameter int unsigned COUNT_WIDTH    = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration writes
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  // byte stream in
  input  logic        req_valid_i,
  output logic        req_stall_o,
  input  logic [7:0]  in_byte_i,
  // results out
  output logic        rsp_valid_o,
  input  logic        rsp_stall_i,
  output logic [7:0]  out_byte_o,
  output logic        out_valid_o,
  output logic [31:0] total_codewords_o,
  output logic [31:0] error_codewords_o
);

  localparam int unsigned SW  = 8 + GEN_MAX_LENGTH - 1;   // codeword register width
  localparam int unsigned EW  = SW + 8;                    // register plus one byte
  localparam int unsigned GW  = SW + 16;                   // generator masking width
  localparam int unsigned LW  = $clog2(GEN_MAX_LENGTH + 1);
  localparam int unsigned CLW = $clog2(SW + 1);
  localparam int unsigned AW  = CLW + 2;                   // bit position arithmetic

  // configuration registers
  logic [15:0] gen_bits_q;
  logic [4:0]  gen_len_q;
  logic        wide_q;

  // stream state
  crcsc_pkg::phase_e      phase_q, phase_d;
  logic [3:0]             pad_q, pad_d;
  logic [SW-1:0]          shift_q, shift_d;
  logic [4:0]             fill_q, fill_d;
  logic [3:0]             nib_q, nib_d;
  logic                   held_q, held_d;
  logic [COUNT_WIDTH-1:0] total_q, total_d;
  logic [COUNT_WIDTH-1:0] err_q, err_d;

  // framing
  logic [LW-1:0] len_l;
  logic [AW-1:0] data_len;
  logic [AW-1:0] cw_len;
  logic [AW-1:0] align_sh;
  logic [GW-1:0] gen_full;
  logic [GW-1:0] gen_shifted;
  logic [SW-1:0] gen_al;
  logic [3:0]    n_bits;
  logic [8:0]    fed_mask;
  logic [EW-1:0] ext;
  logic [AW-1:0] k1, k2;
  logic [AW-1:0] fill_sum;
  logic          can_done;
  logic [1:0]    done_v;
  logic [2:0]    sh1, sh2;
  logic [EW-1:0] win1, win2;
  logic [SW-1:0] cw1, cw2;

  crcsc_pkg::check_t chk_v [2];

  // packing and counting
  logic       byte_val;
  logic [7:0] byte_out;
  logic [1:0] inc_total;
  logic [1:0] inc_err;

  // handshake and output buffer
  logic                 in_acc;
  logic                 pop;
  crcsc_pkg::result_t   res_d;
  crcsc_pkg::result_t   main_q, skid_q;
  logic                 main_valid_q, skid_valid_q;

  function automatic logic [COUNT_WIDTH-1:0] sat_add(input logic [COUNT_WIDTH-1:0] cnt,
                                                     input logic [1:0] inc);
    logic [COUNT_WIDTH:0] sum;
    sum = {1'b0, cnt} + (COUNT_WIDTH + 1)'(inc);
    return sum[COUNT_WIDTH] ? {COUNT_WIDTH{1'b1}} : sum[COUNT_WIDTH-1:0];
  endfunction

  // configuration port, always ready
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gen_bits_q <= crcsc_pkg::GEN_BITS_RESET;
      gen_len_q  <= crcsc_pkg::GEN_LENGTH_RESET;
      wide_q     <= 1'b0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        crcsc_pkg::CFG_GEN_BITS:      gen_bits_q <= cfg_data_i;
        crcsc_pkg::CFG_GEN_LENGTH:    gen_len_q  <= cfg_data_i[4:0];
        crcsc_pkg::CFG_WIDE_DATAWORD: wide_q     <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // generator length clamped to the supported range
  always_comb begin
    if (gen_len_q < 5'd2) begin
      len_l = LW'(2);
    end else if (gen_len_q > GEN_MAX_LENGTH) begin
      len_l = LW'(GEN_MAX_LENGTH);
    end else begin
      len_l = LW'(gen_len_q);
    end
  end

  // codeword length and generator aligned to the top of the register
  assign data_len    = AW'(wide_q ? crcsc_pkg::WIDE_DATA_BITS : crcsc_pkg::NARROW_DATA_BITS);
  assign cw_len      = data_len + AW'(len_l) - AW'(1);
  assign align_sh    = AW'(SW) - cw_len;
  assign gen_full    = GW'(gen_bits_q) & ((GW'(1) << len_l) - GW'(1));
  assign gen_shifted = gen_full << (AW'(SW) - AW'(len_l));
  assign gen_al      = gen_shifted[SW-1:0];

  // header handling: how many bits of this byte enter the codeword stream
  always_comb begin
    phase_d = phase_q;
    pad_d   = pad_q;
    n_bits  = 4'd0;
    case (phase_q)
      crcsc_pkg::PH_PAD_COUNT: begin
        phase_d = crcsc_pkg::PH_FIRST_BYTE;
        pad_d   = (in_byte_i >= 8'(crcsc_pkg::PAD_MAX)) ? crcsc_pkg::PAD_MAX : in_byte_i[3:0];
      end
      crcsc_pkg::PH_FIRST_BYTE: begin
        phase_d = crcsc_pkg::PH_STREAM;
        n_bits  = 4'd8 - pad_q;
      end
      crcsc_pkg::PH_STREAM: begin
        n_bits = 4'd8;
      end
      default: begin
        phase_d = crcsc_pkg::PH_PAD_COUNT;
      end
    endcase
  end

  // codeword register with the fed bits appended
  assign fed_mask = (9'd1 << n_bits) - 9'd1;
  assign ext      = (EW'(shift_q) << n_bits) | EW'(in_byte_i & fed_mask[7:0]);
  assign shift_d  = ext[SW-1:0];

  // where in this byte codewords close: at most two, the codeword being longer than 4 bits
  assign can_done  = (cw_len <= AW'(crcsc_pkg::FILL_MAX));
  assign k1        = ((AW'(fill_q) + AW'(1)) >= cw_len) ? AW'(1) : (cw_len - AW'(fill_q));
  assign k2        = k1 + cw_len;
  assign done_v[0] = can_done && (k1 <= AW'(n_bits));
  assign done_v[1] = done_v[0] && (k2 <= AW'(n_bits));
  assign fill_sum  = AW'(fill_q) + AW'(n_bits);

  always_comb begin
    if (done_v[1]) begin
      fill_d = 5'(AW'(n_bits) - k2);
    end else if (done_v[0]) begin
      fill_d = 5'(AW'(n_bits) - k1);
    end else if (fill_sum > AW'(crcsc_pkg::FILL_MAX)) begin
      fill_d = crcsc_pkg::FILL_MAX;
    end else begin
      fill_d = fill_sum[4:0];
    end
  end

  // closed codewords, left-aligned so the division runs at fixed positions
  assign sh1  = 3'(AW'(n_bits) - k1);
  assign sh2  = 3'(AW'(n_bits) - k2);
  assign win1 = (ext >> sh1) << align_sh;
  assign win2 = (ext >> sh2) << align_sh;
  assign cw1  = win1[SW-1:0];
  assign cw2  = win2[SW-1:0];

  crcsc_divider #(
    .SHIFT_WIDTH (SW)
  ) u_div_first (
    .codeword_i  (cw1),
    .generator_i (gen_al),
    .wide_i      (wide_q),
    .check_o     (chk_v[0])
  );

  crcsc_divider #(
    .SHIFT_WIDTH (SW)
  ) u_div_second (
    .codeword_i  (cw2),
    .generator_i (gen_al),
    .wide_i      (wide_q),
    .check_o     (chk_v[1])
  );

  // pack datawords into bytes, nibble pairs in narrow mode
  always_comb begin
    nib_d    = nib_q;
    held_d   = held_q;
    byte_val = 1'b0;
    byte_out = 8'd0;
    for (int j = 0; j < 2; j++) begin
      if (done_v[j]) begin
        if (wide_q) begin
          byte_out = chk_v[j].data;
          byte_val = 1'b1;
          held_d   = 1'b0;
        end else if (held_d) begin
          byte_out = {nib_d, chk_v[j].data[3:0]};
          byte_val = 1'b1;
          held_d   = 1'b0;
        end else begin
          nib_d  = chk_v[j].data[3:0];
          held_d = 1'b1;
        end
      end
    end
  end

  // saturating codeword and error counters
  assign inc_total = {1'b0, done_v[0]} + {1'b0, done_v[1]};
  assign inc_err   = {1'b0, done_v[0] & chk_v[0].error} + {1'b0, done_v[1] & chk_v[1].error};
  assign total_d   = sat_add(total_q, inc_total);
  assign err_d     = sat_add(err_q, inc_err);

  // result of this request
  always_comb begin
    res_d.out_byte        = byte_out;
    res_d.out_valid       = byte_val;
    res_d.total_codewords = 32'(total_d);
    res_d.error_codewords = 32'(err_d);
  end

  // stream state update on each accepted request
  assign in_acc = req_valid_i && !skid_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= crcsc_pkg::PH_PAD_COUNT;
      pad_q   <= 4'd0;
      shift_q <= '0;
      fill_q  <= 5'd0;
      nib_q   <= 4'd0;
      held_q  <= 1'b0;
      total_q <= '0;
      err_q   <= '0;
    end else if (in_acc) begin
      phase_q <= phase_d;
      pad_q   <= pad_d;
      shift_q <= shift_d;
      fill_q  <= fill_d;
      nib_q   <= nib_d;
      held_q  <= held_d;
      total_q <= total_d;
      err_q   <= err_d;
    end
  end

  // output buffer control: main entry drives the port, skid entry catches overflow
  assign pop = main_valid_q && !rsp_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (pop) begin
      main_valid_q <= skid_valid_q || in_acc;
      skid_valid_q <= 1'b0;
    end else if (!main_valid_q) begin
      main_valid_q <= in_acc;
    end else if (in_acc) begin
      skid_valid_q <= 1'b1;
    end
  end

  // output buffer payload
  always_ff @(posedge clk_i) begin
    if (pop) begin
      main_q <= skid_valid_q ? skid_q : res_d;
    end else if (!main_valid_q) begin
      main_q <= res_d;
    end else if (in_acc) begin
      skid_q <= res_d;
    end
  end

  assign req_stall_o       = skid_valid_q;
  assign rsp_valid_o       = main_valid_q;
  assign out_byte_o        = main_q.out_byte;
  assign out_valid_o       = main_q.out_valid;
  assign total_codewords_o = main_q.total_codewords;
  assign error_codewords_o = main_q.error_codewords;

endmodule

// ===== hw/rtl/crcsc_checker.sv =====
// crcsc_checker: port-level checks on the crc codeword stream checker
// no package dependency; bound to the top level at the end of this file

module crcsc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        req_stall_o,
  input logic        rsp_valid_o,
  input logic        rsp_stall_i,
  input logic [7:0]  out_byte_o,
  input logic        out_valid_o,
  input logic [31:0] total_codewords_o,
  input logic [31:0] error_codewords_o
);

  // reset empties the output buffer
  a_reset_empty: assert property (@(posedge clk_i)
    !rst_ni |=> !rsp_valid_o && !req_stall_o)
    else $error("output buffer not empty under reset");

  // requests stall only while a result is on offer
  a_stall_needs_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_stall_o |-> rsp_valid_o)
    else $error("request side stalled with no result pending");

  // a result without a completed byte carries a zero byte
  a_idle_byte_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && !out_valid_o |-> out_byte_o == 8'd0)
    else $error("data byte set on a result without a completed byte");

  // a stalled result stays on offer unchanged
  a_stalled_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && rsp_stall_i |=> rsp_valid_o && $stable(out_byte_o) &&
      $stable(out_valid_o) && $stable(total_codewords_o) && $stable(error_codewords_o))
    else $error("stalled result changed or withdrawn");

endmodule

bind crc_codeword_stream_checker crcsc_checker u_crcsc_checker (.*);
